/* hw/rtl/cwp_pkg.sv */
// Shared types and constants for the two-way cache with way predictor.
package cwp_pkg;

    localparam int ADDR_W    = 64;
    localparam int COUNT_W   = 32;
    localparam int TRAFFIC_W = 38;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } cwp_state_t;

    // per-set bookkeeping row: lru holds the most recently used way
    typedef struct packed {
        logic       lru;
        logic [1:0] valid;
        logic [1:0] dirty;
    } set_state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic commit;
    } cwp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_stall;
    } cwp_status_t;

endpackage

/* hw/rtl/cwp_req_if.sv */
// Request channel: one load or store access.
interface cwp_req_if;
    import cwp_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

/* hw/rtl/cwp_rsp_if.sv */
// Response channel: lookup outcome and running totals.
interface cwp_rsp_if;
    import cwp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic                 way;
    logic                 mispredict;
    logic                 writeback;
    logic [COUNT_W-1:0]   hit_count;
    logic [COUNT_W-1:0]   miss_count;
    logic [COUNT_W-1:0]   mispredict_count;
    logic [TRAFFIC_W-1:0] traffic_bytes;

    modport source (
        output valid, output hit, output way, output mispredict, output writeback,
        output hit_count, output miss_count, output mispredict_count,
        output traffic_bytes, input ready
    );
    modport sink (
        input valid, input hit, input way, input mispredict, input writeback,
        input hit_count, input miss_count, input mispredict_count,
        input traffic_bytes, output ready
    );
endinterface

/* hw/rtl/cwp_ctrl.sv */
// Controller state machine: clearing pass, request accept and commit sequencing.
module cwp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  cwp_pkg::cwp_status_t status,
    output cwp_pkg::cwp_cmd_t    cmd
);
    import cwp_pkg::*;

    cwp_state_t state_reg;
    cwp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!status.out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.clear  = 1'b0;
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            ST_LOOKUP:
            begin
                cmd.commit = !status.out_stall;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/cwp_datapath.sv */
// Datapath: tag, set state and predictor memories, hit logic, totals and response register.
module cwp_datapath #(
    parameter int SETS              = 512,
    parameter int PREDICTOR_ENTRIES = 65536,
    parameter int LINE_OFFSET_BITS  = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cwp_pkg::cwp_cmd_t                 cmd,
    output cwp_pkg::cwp_status_t              status,
    input  logic                              operation,
    input  logic [cwp_pkg::ADDR_W-1:0]        address,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              out_hit,
    output logic                              out_way,
    output logic                              out_mispredict,
    output logic                              out_writeback,
    output logic [cwp_pkg::COUNT_W-1:0]       hit_count,
    output logic [cwp_pkg::COUNT_W-1:0]       miss_count,
    output logic [cwp_pkg::COUNT_W-1:0]       mispredict_count,
    output logic [cwp_pkg::TRAFFIC_W-1:0]     traffic_bytes
);
    import cwp_pkg::*;

    localparam int SET_W     = $clog2(SETS);
    localparam int PRED_W    = $clog2(PREDICTOR_ENTRIES);
    localparam int TAG_W     = ADDR_W - LINE_OFFSET_BITS - SET_W;
    localparam int CLR_DEPTH = (SETS > PREDICTOR_ENTRIES) ? SETS : PREDICTOR_ENTRIES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    logic [TAG_W-1:0]   tag0_mem [SETS];
    logic [TAG_W-1:0]   tag1_mem [SETS];
    set_state_t         state_mem [SETS];
    logic               pred_mem [PREDICTOR_ENTRIES];

    logic [CLR_W-1:0]   clr_cnt_reg;
    logic [CLR_W-1:0]   clr_cnt_next;

    logic               op_reg;
    logic [SET_W-1:0]   set_reg;
    logic [PRED_W-1:0]  pidx_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag0_rd_reg;
    logic [TAG_W-1:0]   tag1_rd_reg;
    set_state_t         state_rd_reg;
    logic               pred_rd_reg;

    logic [COUNT_W-1:0] hits_reg;
    logic [COUNT_W-1:0] misses_reg;
    logic [COUNT_W-1:0] mispred_reg;
    logic [COUNT_W-1:0] wbs_reg;

    logic               out_valid_reg;
    logic               out_hit_reg;
    logic               out_way_reg;
    logic               out_mis_reg;
    logic               out_wb_reg;

    logic               hit0;
    logic               hit1;
    logic               hit;
    logic               way;
    logic               mis;
    logic               wb;
    logic               is_store;
    set_state_t         state_new;

    logic               state_we;
    logic [SET_W-1:0]   state_waddr;
    set_state_t         state_wdata;
    logic               pred_we;
    logic [PRED_W-1:0]  pred_waddr;
    logic               pred_wdata;
    logic               clr_set_en;
    logic               clr_pred_en;

    // clearing pass
    assign clr_set_en        = ({1'b0, clr_cnt_reg} < (CLR_W+1)'(SETS));
    assign clr_pred_en       = ({1'b0, clr_cnt_reg} < (CLR_W+1)'(PREDICTOR_ENTRIES));
    assign status.clear_last = (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1));
    assign clr_cnt_next      = clr_cnt_reg + CLR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear && !status.clear_last)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // lookup
    assign is_store = (op_reg == OP_STORE);
    assign hit0     = state_rd_reg.valid[0] && (tag0_rd_reg == tag_reg);
    assign hit1     = state_rd_reg.valid[1] && (tag1_rd_reg == tag_reg);
    assign hit      = hit0 || hit1;
    assign way      = hit0 ? 1'b0 : (hit1 ? 1'b1 : ~state_rd_reg.lru);
    assign mis      = hit && (pred_rd_reg != way);
    assign wb       = !hit && state_rd_reg.valid[way] && state_rd_reg.dirty[way];

    always_comb
    begin
        state_new            = state_rd_reg;
        state_new.lru        = way;
        state_new.valid[way] = 1'b1;
        state_new.dirty[way] = hit ? (state_rd_reg.dirty[way] || is_store) : is_store;
    end

    always_comb
    begin
        state_we    = cmd.commit;
        state_waddr = set_reg;
        state_wdata = state_new;
        pred_we     = cmd.commit;
        pred_waddr  = pidx_reg;
        pred_wdata  = way;
        if (cmd.clear)
        begin
            state_we    = clr_set_en;
            state_waddr = clr_cnt_reg[SET_W-1:0];
            state_wdata = '0;
            pred_we     = clr_pred_en;
            pred_waddr  = clr_cnt_reg[PRED_W-1:0];
            pred_wdata  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_we)
        begin
            state_mem[state_waddr] <= state_wdata;
        end
        if (pred_we)
        begin
            pred_mem[pred_waddr] <= pred_wdata;
        end
        if (cmd.commit && !hit && !way)
        begin
            tag0_mem[set_reg] <= tag_reg;
        end
        if (cmd.commit && !hit && way)
        begin
            tag1_mem[set_reg] <= tag_reg;
        end
    end

    // request capture and registered memory reads
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= operation;
            set_reg      <= address[LINE_OFFSET_BITS +: SET_W];
            pidx_reg     <= address[LINE_OFFSET_BITS +: PRED_W];
            tag_reg      <= address[ADDR_W-1 -: TAG_W];
            tag0_rd_reg  <= tag0_mem[address[LINE_OFFSET_BITS +: SET_W]];
            tag1_rd_reg  <= tag1_mem[address[LINE_OFFSET_BITS +: SET_W]];
            state_rd_reg <= state_mem[address[LINE_OFFSET_BITS +: SET_W]];
            pred_rd_reg  <= pred_mem[address[LINE_OFFSET_BITS +: PRED_W]];
        end
    end

    // saturating totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg    <= '0;
            misses_reg  <= '0;
            mispred_reg <= '0;
            wbs_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            if (hit && (hits_reg != '1))
            begin
                hits_reg <= hits_reg + COUNT_W'(1);
            end
            if (!hit && (misses_reg != '1))
            begin
                misses_reg <= misses_reg + COUNT_W'(1);
            end
            if (mis && (mispred_reg != '1))
            begin
                mispred_reg <= mispred_reg + COUNT_W'(1);
            end
            if (wb && (wbs_reg != '1))
            begin
                wbs_reg <= wbs_reg + COUNT_W'(1);
            end
        end
    end

    // response register
    assign status.out_stall = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg <= hit;
            out_way_reg <= way;
            out_mis_reg <= mis;
            out_wb_reg  <= wb;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_hit          = out_hit_reg;
    assign out_way          = out_way_reg;
    assign out_mispredict   = out_mis_reg;
    assign out_writeback    = out_wb_reg;
    assign hit_count        = hits_reg;
    assign miss_count       = misses_reg;
    assign mispredict_count = mispred_reg;
    assign traffic_bytes    = (TRAFFIC_W'(misses_reg) + TRAFFIC_W'(wbs_reg))
                              << LINE_OFFSET_BITS;

endmodule

/* hw/rtl/two_way_cache_with_way_predictor_top.sv */
// Top level of the two-way set-associative cache model with way predictor.
// One request is handled at a time. The request is accepted in the idle state,
// which reads the single-port tag, set state and predictor memories into
// registers; the lookup state then writes them back and loads the response
// register, which sets the response valid. A new request is not accepted until
// that lookup has committed. While a response waits on rsp.ready, a further
// request can be accepted but its lookup holds until the response is taken.
// After reset a clearing pass zeroes the set state and predictor memories with
// req.ready low. SETS and PREDICTOR_ENTRIES must be powers of two.
module two_way_cache_with_way_predictor_top #(
    parameter int SETS              = 512,
    parameter int PREDICTOR_ENTRIES = 65536,
    parameter int LINE_OFFSET_BITS  = 5
) (
    input logic      clk,
    input logic      rst_n,
    cwp_req_if.sink  req,
    cwp_rsp_if.source rsp
);
    import cwp_pkg::*;

    cwp_cmd_t    cmd;
    cwp_status_t status;

    cwp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cwp_datapath #(
        .SETS              (SETS),
        .PREDICTOR_ENTRIES (PREDICTOR_ENTRIES),
        .LINE_OFFSET_BITS  (LINE_OFFSET_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .operation        (req.operation),
        .address          (req.address),
        .out_ready        (rsp.ready),
        .out_valid        (rsp.valid),
        .out_hit          (rsp.hit),
        .out_way          (rsp.way),
        .out_mispredict   (rsp.mispredict),
        .out_writeback    (rsp.writeback),
        .hit_count        (rsp.hit_count),
        .miss_count       (rsp.miss_count),
        .mispredict_count (rsp.mispredict_count),
        .traffic_bytes    (rsp.traffic_bytes)
    );

endmodule

/* hw/rtl/cwp_checker.sv */
// Port-level assertions for the cache top level, with the bind that attaches them.
module cwp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic                         rsp_hit,
    input logic                         rsp_way,
    input logic                         rsp_mispredict,
    input logic                         rsp_writeback,
    input logic [cwp_pkg::COUNT_W-1:0]  rsp_hit_count
);
    import cwp_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_way) && $stable(rsp_hit_count))
        else $error("response changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted during lookup");

    a_no_wb_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit |-> !rsp_writeback)
        else $error("writeback reported on a hit");

    a_no_mispredict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> !rsp_mispredict)
        else $error("mispredict reported on a miss");

endmodule

bind two_way_cache_with_way_predictor_top cwp_checker u_cwp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_hit        (rsp.hit),
    .rsp_way        (rsp.way),
    .rsp_mispredict (rsp.mispredict),
    .rsp_writeback  (rsp.writeback),
    .rsp_hit_count  (rsp.hit_count)
);
